// ===== hw/rtl/kbss_pkg.sv =====
// Package of constants, types and the byte swap function of the keyed byte swap shuffle.
package kbss_pkg;

    localparam int SWAP_STEPS      = 64;
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = (SWAP_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    localparam int KEY_REGS    = 8;
    localparam int KEY_BYTES   = KEY_REGS * 8;
    localparam int KEY_IDX_W   = $clog2(KEY_BYTES);
    localparam int REG_W       = 64;
    localparam int CFG_ADDR_W  = 4;
    localparam int BLOCK_BYTES = 16;
    localparam int DATA_W      = BLOCK_BYTES * 8;

    localparam logic [CFG_ADDR_W-1:0] LAST_KEY_REG = CFG_ADDR_W'(KEY_REGS - 1);

    localparam logic [7:0] LO_MASK = 8'h0F;
    localparam logic [7:0] HI_MASK = 8'hF0;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef logic [BLOCK_BYTES-1:0][7:0] t_block;
    typedef logic [KEY_BYTES-1:0][7:0]   t_key;

    function automatic t_block swap_bytes(t_block b, logic [7:0] kb);
        logic [3:0] lo;
        logic [3:0] hi;
        t_block     r;
        lo = 4'(kb & LO_MASK);
        hi = 4'((kb & HI_MASK) >> 4);
        r  = b;
        r[lo] = b[hi];
        r[hi] = b[lo];
        return r;
    endfunction

endpackage

// ===== hw/rtl/keyed_byte_swap_shuffle.sv =====
// Top level of the keyed byte swap shuffle: key registers and the swap pipeline.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tdata: block_low, block_high; tuser: cmd
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: out_low, out_high
//  cfg      | in        | i_cfg_we               | i_cfg_addr, i_cfg_wdata (key registers)
//
// One item enters per cycle while the output is not stalled; each pipeline stage applies four key swaps.
// Each stage registers its block, so an item passes through every stage of the swap chain.
// Synchronous active-low reset clears the key registers and all stage valid bits.
// A stall at the output freezes every stage, so nothing is lost or repeated.
module keyed_byte_swap_shuffle (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kbss_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [kbss_pkg::REG_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [kbss_pkg::DATA_W-1:0]        s_axis_tdata,  // block_low, block_high
    input  logic                               s_axis_tuser,  // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [kbss_pkg::DATA_W-1:0]        m_axis_tdata   // out_low, out_high
);

    localparam int NS = kbss_pkg::NUM_STAGES;
    localparam int SP = kbss_pkg::STEPS_PER_STAGE;

    logic [kbss_pkg::KEY_REGS-1:0][kbss_pkg::REG_W-1:0] r_key;
    kbss_pkg::t_key   w_key;
    logic             w_en;

    logic             r_valid [NS];
    logic             r_dir   [NS];
    kbss_pkg::t_block r_blk   [NS];
    kbss_pkg::t_block n_blk   [NS];

    assign w_key = kbss_pkg::t_key'(r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we && i_cfg_addr <= kbss_pkg::LAST_KEY_REG) begin
            r_key[i_cfg_addr[kbss_pkg::KEY_IDX_W-4:0]] <= i_cfg_wdata;
        end
    end

    assign w_en          = !r_valid[NS-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        kbss_pkg::t_block w_src;
        logic             w_dir;

        if (s == 0) begin : g_first
            assign w_src = kbss_pkg::t_block'(s_axis_tdata);
            assign w_dir = s_axis_tuser;
        end else begin : g_rest
            assign w_src = r_blk[s-1];
            assign w_dir = r_dir[s-1];
        end

        kbss_pkg::t_block w_chain [SP+1];
        assign w_chain[0] = w_src;

        for (genvar t = 0; t < SP; t++) begin : g_step
            localparam int J = s * SP + t;
            if (J < kbss_pkg::SWAP_STEPS) begin : g_on
                localparam logic [kbss_pkg::KEY_IDX_W-1:0] K_FWD =
                    kbss_pkg::KEY_IDX_W'(J);
                localparam logic [kbss_pkg::KEY_IDX_W-1:0] K_REV =
                    kbss_pkg::KEY_IDX_W'(kbss_pkg::SWAP_STEPS - 1 - J);
                logic [7:0] w_kb;
                assign w_kb = (w_dir == kbss_pkg::DIR_DECRYPT) ? w_key[K_FWD] : w_key[K_REV];
                assign w_chain[t+1] = kbss_pkg::swap_bytes(w_chain[t], w_kb);
            end else begin : g_off
                assign w_chain[t+1] = w_chain[t];
            end
        end

        assign n_blk[s] = w_chain[SP];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_en) begin
                r_valid[s] <= (s == 0) ? s_axis_tvalid : r_valid[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_blk[s] <= n_blk[s];
                r_dir[s] <= w_dir;
            end
        end
    end

    assign m_axis_tvalid = r_valid[NS-1];
    assign m_axis_tdata  = kbss_pkg::DATA_W'(r_blk[NS-1]);

endmodule

// ===== hw/rtl/kbss_checker.sv =====
// Port-level assertion checker of the keyed byte swap shuffle, with its bind statement.
module kbss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [kbss_pkg::DATA_W-1:0]     m_axis_tdata
);

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output item withdrawn while stalled.");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Output item changed while stalled.");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("Input accepted while the pipeline is stalled.");

    a_empty_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("Output valid straight after reset.");

endmodule

bind keyed_byte_swap_shuffle kbss_checker u_kbss_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the keyed byte swap shuffle: key loads, directed and random blocks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HANG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = kbss_pkg::NUM_STAGES + 4;
    localparam int RANDOM_ITEMS = 260;

    localparam logic [kbss_pkg::CFG_ADDR_W-1:0] FIRST_UNUSED_REG =
        kbss_pkg::CFG_ADDR_W'(kbss_pkg::KEY_REGS);
    localparam logic [127:0] RAMP_BLOCK = 128'h0f0e0d0c0b0a09080706050403020100;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } t_shuffled;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic [kbss_pkg::CFG_ADDR_W-1:0]   i_cfg_addr    = '0;
    logic [kbss_pkg::REG_W-1:0]        i_cfg_wdata   = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [kbss_pkg::DATA_W-1:0]       s_axis_tdata  = '0;
    logic                              s_axis_tuser  = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [kbss_pkg::DATA_W-1:0]       m_axis_tdata;

    logic [kbss_pkg::REG_W-1:0] key_copy [kbss_pkg::KEY_REGS];
    t_shuffled        expected_blocks [$];
    logic             stall_enable = 1'b1;
    int               fail_count   = 0;
    int               quiet_cycles = 0;

    keyed_byte_swap_shuffle u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_shuffled shuffle_block(input logic cmd, input logic [63:0] blk_low,
                                                input logic [63:0] blk_high);
        logic [7:0] bytes [kbss_pkg::BLOCK_BYTES];
        logic [7:0] kb;
        logic [7:0] held;
        int         k;
        t_shuffled  r;
        for (int i = 0; i < 8; i++) begin
            bytes[i]     = blk_low[8*i +: 8];
            bytes[8 + i] = blk_high[8*i +: 8];
        end
        for (int s = 0; s < kbss_pkg::SWAP_STEPS; s++) begin
            k    = (cmd == kbss_pkg::DIR_DECRYPT) ? s : kbss_pkg::SWAP_STEPS - 1 - s;
            kb   = key_copy[k[5:3]][8*k[2:0] +: 8];
            held = bytes[kb[3:0]];
            bytes[kb[3:0]] = bytes[kb[7:4]];
            bytes[kb[7:4]] = held;
        end
        for (int i = 0; i < 8; i++) begin
            r.out_low[8*i +: 8]  = bytes[i];
            r.out_high[8*i +: 8] = bytes[8 + i];
        end
        return r;
    endfunction

    function automatic kbss_pkg::t_key random_key(input bit equal_nibbles);
        kbss_pkg::t_key key;
        for (int b = 0; b < kbss_pkg::KEY_BYTES; b++) begin
            key[b] = 8'($urandom);
            if (equal_nibbles && $urandom_range(0, 3) != 0) begin
                key[b][7:4] = key[b][3:0];
            end
        end
        return key;
    endfunction

    task automatic send_block(input logic cmd, input logic [63:0] blk_low,
                              input logic [63:0] blk_high);
        if (stall_enable && $urandom_range(0, 99) < 4) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blk_high, blk_low};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_blocks.push_back(shuffle_block(cmd, blk_low, blk_high));
    endtask

    task automatic send_random_blocks(input int count);
        repeat (count) begin
            send_block(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kbss_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [kbss_pkg::REG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (addr < FIRST_UNUSED_REG) begin
            key_copy[addr[2:0]] = value;
        end
    endtask

    task automatic write_key_regs(input kbss_pkg::t_key key);
        for (int r = 0; r < kbss_pkg::KEY_REGS; r++) begin
            write_reg(kbss_pkg::CFG_ADDR_W'(r), kbss_pkg::REG_W'(key[8*r +: 8]));
        end
    endtask

    task automatic load_key(input kbss_pkg::t_key key);
        wait_drained();
        write_key_regs(key);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_key();
        send_block(kbss_pkg::DIR_ENCRYPT, '0, '0);
        send_block(kbss_pkg::DIR_DECRYPT, '1, '1);
        send_block(kbss_pkg::DIR_ENCRYPT, RAMP_BLOCK[63:0], RAMP_BLOCK[127:64]);
        send_block(kbss_pkg::DIR_DECRYPT, RAMP_BLOCK[63:0], RAMP_BLOCK[127:64]);
    endtask

    task automatic test_unknown_register();
        kbss_pkg::t_key key;
        for (int b = 0; b < kbss_pkg::KEY_BYTES; b++) begin
            key[b] = 8'(b * 37 + 5);
        end
        wait_drained();
        write_key_regs(key);
        for (int a = kbss_pkg::KEY_REGS; a < 2 ** kbss_pkg::CFG_ADDR_W; a++) begin
            write_reg(kbss_pkg::CFG_ADDR_W'(a), {$urandom, $urandom});
        end
        i_cfg_we <= 1'b0;
        send_block(kbss_pkg::DIR_ENCRYPT, RAMP_BLOCK[63:0], RAMP_BLOCK[127:64]);
        send_block(kbss_pkg::DIR_DECRYPT, RAMP_BLOCK[63:0], RAMP_BLOCK[127:64]);
    endtask

    task automatic test_directed_keys();
        kbss_pkg::t_key keys [3];
        t_shuffled      sealed;
        keys[0] = '1;
        keys[1] = kbss_pkg::t_key'({32{16'hF00F}});
        for (int b = 0; b < kbss_pkg::KEY_BYTES; b++) begin
            keys[2][b] = {4'(b * 5 + 3), 4'(b * 7)};
        end
        foreach (keys[n]) begin
            load_key(keys[n]);
            send_block(kbss_pkg::DIR_ENCRYPT, RAMP_BLOCK[63:0], RAMP_BLOCK[127:64]);
            send_block(kbss_pkg::DIR_DECRYPT, 64'h8000_0000_0000_0001,
                       64'h0123_4567_89AB_CDEF);
            sealed = shuffle_block(kbss_pkg::DIR_ENCRYPT, RAMP_BLOCK[63:0],
                                   RAMP_BLOCK[127:64]);
            send_block(kbss_pkg::DIR_DECRYPT, sealed.out_low, sealed.out_high);
        end
    endtask

    task automatic test_drain_pause();
        load_key(random_key(1'b0));
        send_random_blocks(40);
        wait_drained();
        send_random_blocks(40);
    endtask

    task automatic test_random_keys();
        for (int phase = 0; phase < 5; phase++) begin
            load_key(random_key(phase % 2 == 1));
            send_random_blocks(RANDOM_ITEMS);
        end
    endtask

    task automatic test_no_idle_stretch();
        stall_enable <= 1'b0;
        load_key(random_key(1'b0));
        send_random_blocks(300);
        stall_enable <= 1'b1;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= !(stall_enable && $urandom_range(0, 99) < 8);
    end

    always @(posedge i_clk) begin
        t_shuffled want;
        t_shuffled got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_blocks.size() == 0) begin
                $error("unexpected output item %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_blocks.pop_front();
                if (got.out_low !== want.out_low) begin
                    $error("out_low: expected %h, got %h", want.out_low, got.out_low);
                    fail_count++;
                end
                if (got.out_high !== want.out_high) begin
                    $error("out_high: expected %h, got %h", want.out_high, got.out_high);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (key_copy[r]) key_copy[r] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_unknown_register();
        test_directed_keys();
        test_drain_pause();
        test_random_keys();
        test_no_idle_stretch();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
